// ===== design/pas_pkg.sv =====
// shared types, constants and helper functions of the particle attractor step core
`default_nettype none

package pas_pkg;

  localparam int DT_W    = 17;
  localparam int COORD_W = 32;
  localparam int MASS_W  = 19;
  localparam int KDT_W   = 39;
  localparam int WORD_W  = 64;

  localparam logic [MASS_W-1:0] MASS_RESET = 19'd65536;
  localparam logic [KDT_W-1:0]  PULL_CAP   = {1'b1, 38'b0};

  typedef struct packed {
    logic [DT_W-1:0]           time_step;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } result_t;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE     = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_DIFF     = 5'd2;
  localparam op_t OP_NPREP_D  = 5'd3;
  localparam op_t OP_NPREP_V  = 5'd4;
  localparam op_t OP_NSHIFT   = 5'd5;
  localparam op_t OP_SQ_MUL   = 5'd6;
  localparam op_t OP_SQ_ACC   = 5'd7;
  localparam op_t OP_SQRT     = 5'd8;
  localparam op_t OP_DIST_SET = 5'd9;
  localparam op_t OP_NV_SET   = 5'd10;
  localparam op_t OP_UDIV     = 5'd11;
  localparam op_t OP_USET     = 5'd12;
  localparam op_t OP_T1DIV    = 5'd13;
  localparam op_t OP_KDIV     = 5'd14;
  localparam op_t OP_KDTMUL   = 5'd15;
  localparam op_t OP_KDTSET   = 5'd16;
  localparam op_t OP_PULLMUL  = 5'd17;
  localparam op_t OP_VSET     = 5'd18;
  localparam op_t OP_CLMUL    = 5'd19;
  localparam op_t OP_CLDIV    = 5'd20;
  localparam op_t OP_CLSET    = 5'd21;
  localparam op_t OP_VSTORE   = 5'd22;
  localparam op_t OP_SPMUL    = 5'd23;
  localparam op_t OP_SPSET    = 5'd24;
  localparam op_t OP_SPDMUL   = 5'd25;
  localparam op_t OP_SPDSET   = 5'd26;
  localparam op_t OP_POSMUL   = 5'd27;
  localparam op_t OP_POSSET   = 5'd28;
  localparam op_t OP_OUTLOAD  = 5'd29;

  typedef logic [1:0] kind_t;

  localparam kind_t K_MUL  = 2'd0;
  localparam kind_t K_DIV  = 2'd1;
  localparam kind_t K_SQRT = 2'd2;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic arith_done;
    logic shift_done;
    logic far;
    logic clamp;
  } status_t;

  typedef struct packed {
    logic              start;
    kind_t             kind;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } arith_cmd_t;

  function automatic logic [WORD_W-1:0] mag64(input logic [WORD_W-1:0] a);
    return a[WORD_W-1] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [WORD_W-1:0] with_sign64(input logic [WORD_W-1:0] m,
                                                    input logic neg);
    return neg ? (64'd0 - m) : m;
  endfunction

  function automatic logic [WORD_W-1:0] sext32(input logic [COORD_W-1:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [COORD_W-1:0] sat32(input logic [WORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (!v[63] && (v[62:31] != '0)) begin
      r = 32'h7fff_ffff;
    end else if (v[63] && (v[62:31] != '1)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/pas_arith.sv =====
// shared iterative unit: 64-bit multiply, restoring divide and integer square root
`default_nettype none

module pas_arith import pas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  arith_cmd_t        cmd,
  output logic [WORD_W-1:0] res,
  output logic              done
);

  localparam logic [5:0] LAST_MUL  = 6'd2;
  localparam logic [5:0] LAST_DIV  = 6'd63;
  localparam logic [5:0] LAST_SQRT = 6'd31;

  logic              busy;
  kind_t             kind;
  logic [5:0]        cnt;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;
  logic [WORD_W-1:0] acc;
  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] bitv;

  logic [WORD_W-1:0] acc_next;
  logic [WORD_W:0]   rem_next;
  logic [WORD_W-1:0] bitv_next;
  logic [5:0]        last;

  logic [31:0]       mop_a;
  logic [31:0]       mop_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W-1:0] trial;

  assign mop_a  = (cnt == 6'd2) ? opa[63:32] : opa[31:0];
  assign mop_b  = (cnt == 6'd1) ? opb[63:32] : opb[31:0];
  assign prod   = {32'b0, mop_a} * {32'b0, mop_b};
  assign rem_sh = {rem[WORD_W-1:0], acc[WORD_W-1]};
  assign trial  = acc + bitv;
  assign res    = acc;

  always_comb begin
    acc_next  = acc;
    rem_next  = rem;
    bitv_next = bitv;
    last      = LAST_MUL;
    unique case (kind)
      K_MUL: begin
        last     = LAST_MUL;
        acc_next = acc + ((cnt == 6'd0) ? prod : {prod[31:0], 32'b0});
      end
      K_DIV: begin
        last = LAST_DIV;
        if (rem_sh >= {1'b0, opb}) begin
          rem_next = rem_sh - {1'b0, opb};
          acc_next = {acc[WORD_W-2:0], 1'b1};
        end else begin
          rem_next = rem_sh;
          acc_next = {acc[WORD_W-2:0], 1'b0};
        end
      end
      K_SQRT: begin
        last      = LAST_SQRT;
        bitv_next = bitv >> 2;
        if (rem[WORD_W-1:0] >= trial) begin
          rem_next = {1'b0, rem[WORD_W-1:0] - trial};
          acc_next = (acc >> 1) + bitv;
        end else begin
          acc_next = acc >> 1;
        end
      end
      default: begin
        last = LAST_MUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        kind <= cmd.kind;
        cnt  <= '0;
        opa  <= cmd.a;
        opb  <= cmd.b;
        bitv <= {2'b01, 62'b0};
        unique case (cmd.kind)
          K_DIV: begin
            acc <= cmd.a;
            rem <= '0;
          end
          K_SQRT: begin
            acc <= '0;
            rem <= {1'b0, cmd.a};
          end
          default: begin
            acc <= '0;
            rem <= '0;
          end
        endcase
      end else if (busy) begin
        acc  <= acc_next;
        rem  <= rem_next;
        bitv <= bitv_next;
        cnt  <= cnt + 6'd1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pas_datapath.sv =====
// datapath: particle state, scratch registers and operand selection for the shared unit
`default_nettype none

module pas_datapath import pas_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  item_t             item,
  input  logic              cfg_we,
  input  logic [MASS_W-1:0] cfg_wdata,
  output logic [MASS_W-1:0] mass,
  output status_t           status,
  output result_t           result
);

  localparam logic [WORD_W-1:0] One    = 64'd1 << FRAC_BITS;
  localparam logic [WORD_W-1:0] Near   = (One + 64'd50) / 64'd100;
  localparam logic [WORD_W-1:0] Spring = (One * 64'd10 + 64'd50) / 64'd100;
  localparam logic [WORD_W-1:0] Vmax   = (One * 64'd20 + 64'd50) / 64'd100;

  logic [COORD_W-1:0] pos [3];
  logic [COORD_W-1:0] vel [3];
  logic [COORD_W-1:0] tgt [3];
  logic [DT_W-1:0]    dt;

  logic [WORD_W-1:0]  d     [3];
  logic [WORD_W-1:0]  v     [3];
  logic [WORD_W-1:0]  speed [3];
  logic [WORD_W-1:0]  m     [3];
  logic [FRAC_BITS:0] u_mag [3];
  logic [2:0]         u_neg;

  logic [WORD_W-1:0]  mx_w;
  logic [WORD_W-1:0]  sum;
  logic [WORD_W-1:0]  dlen;
  logic [WORD_W-1:0]  nv;
  logic [WORD_W-1:0]  sp;
  logic [5:0]         s;
  logic [KDT_W-1:0]   kdt;

  arith_cmd_t         acmd;
  logic [WORD_W-1:0]  ares;
  logic               adone;

  logic [WORD_W-1:0]  ares_fx;
  logic [WORD_W-1:0]  q_cap;
  logic [WORD_W-1:0]  sp_base;
  logic [WORD_W-1:0]  nmag [3];
  logic [WORD_W-1:0]  nmax;
  logic [WORD_W-1:0]  sq_op;

  pas_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .cmd  (acmd),
    .res  (ares),
    .done (adone)
  );

  assign ares_fx = ares >> FRAC_BITS;
  assign q_cap   = (ares > One) ? One : ares;
  assign sp_base = (dlen > Spring) ? (dlen - Spring) : '0;
  assign sq_op   = m[cmd.idx] >> s;

  always_comb begin
    for (logic [1:0] k = 2'd0; k < 2'd3; k++) begin
      nmag[k] = mag64((cmd.op == OP_NPREP_V) ? v[k] : d[k]);
    end
    nmax = nmag[0];
    if (nmag[1] > nmax) nmax = nmag[1];
    if (nmag[2] > nmax) nmax = nmag[2];
  end

  assign status.arith_done = adone;
  assign status.shift_done = (mx_w[63:31] == '0);
  assign status.far        = (dlen > Near);
  assign status.clamp      = (nv > Vmax);

  // operand selection for the shared unit
  always_comb begin
    acmd.start = 1'b1;
    acmd.kind  = K_MUL;
    acmd.a     = '0;
    acmd.b     = '0;
    unique case (cmd.op)
      OP_SQ_MUL: begin
        acmd.a = sq_op;
        acmd.b = sq_op;
      end
      OP_SQRT: begin
        acmd.kind = K_SQRT;
        acmd.a    = sum;
      end
      OP_UDIV: begin
        acmd.kind = K_DIV;
        acmd.a    = mag64(d[cmd.idx]) << FRAC_BITS;
        acmd.b    = dlen;
      end
      OP_T1DIV: begin
        acmd.kind = K_DIV;
        acmd.a    = 64'(mass) << FRAC_BITS;
        acmd.b    = dlen;
      end
      OP_KDIV: begin
        acmd.kind = K_DIV;
        acmd.a    = ares << FRAC_BITS;
        acmd.b    = dlen << 1;
      end
      OP_KDTMUL: begin
        acmd.a = ares;
        acmd.b = 64'(dt);
      end
      OP_PULLMUL: begin
        acmd.a = 64'(kdt);
        acmd.b = 64'(u_mag[cmd.idx]);
      end
      OP_CLMUL: begin
        acmd.a = mag64(v[cmd.idx]);
        acmd.b = Vmax;
      end
      OP_CLDIV: begin
        acmd.kind = K_DIV;
        acmd.a    = ares;
        acmd.b    = nv;
      end
      OP_SPMUL: begin
        acmd.a = sp_base;
        acmd.b = 64'(mass);
      end
      OP_SPDMUL: begin
        acmd.a = sp;
        acmd.b = 64'(u_mag[cmd.idx]);
      end
      OP_POSMUL: begin
        acmd.a = mag64(speed[cmd.idx]);
        acmd.b = 64'(dt);
      end
      default: begin
        acmd.start = 1'b0;
      end
    endcase
  end

  // particle state and mass register
  always_ff @(posedge clk) begin
    if (rst) begin
      mass <= MASS_RESET;
      for (logic [1:0] k = 2'd0; k < 2'd3; k++) begin
        pos[k] <= '0;
        vel[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        mass <= cfg_wdata;
      end
      if (cmd.op == OP_VSTORE) begin
        for (logic [1:0] k = 2'd0; k < 2'd3; k++) begin
          vel[k] <= sat32(v[k]);
        end
      end
      if (cmd.op == OP_POSSET) begin
        pos[cmd.idx] <= sat32(sext32(pos[cmd.idx])
                              + with_sign64(ares_fx, speed[cmd.idx][63]));
      end
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        dt     <= item.time_step;
        tgt[0] <= item.target_x;
        tgt[1] <= item.target_y;
        tgt[2] <= item.target_z;
      end
      OP_DIFF: begin
        for (logic [1:0] k = 2'd0; k < 2'd3; k++) begin
          d[k]     <= sext32(tgt[k]) - sext32(pos[k]);
          speed[k] <= sext32(vel[k]);
        end
      end
      OP_NPREP_D, OP_NPREP_V: begin
        for (logic [1:0] k = 2'd0; k < 2'd3; k++) begin
          m[k] <= nmag[k];
        end
        mx_w <= nmax;
        sum  <= '0;
        s    <= '0;
      end
      OP_NSHIFT: begin
        mx_w <= mx_w >> 1;
        s    <= s + 6'd1;
      end
      OP_SQ_ACC:   sum  <= sum + ares;
      OP_DIST_SET: dlen <= ares << s;
      OP_NV_SET:   nv   <= ares << s;
      OP_USET: begin
        u_mag[cmd.idx] <= q_cap[FRAC_BITS:0];
        u_neg[cmd.idx] <= d[cmd.idx][63];
      end
      OP_KDTSET: begin
        kdt <= (ares_fx > 64'(PULL_CAP)) ? PULL_CAP : ares_fx[KDT_W-1:0];
      end
      OP_VSET: begin
        v[cmd.idx] <= sext32(vel[cmd.idx]) + with_sign64(ares_fx, u_neg[cmd.idx]);
      end
      OP_CLSET: begin
        v[cmd.idx] <= with_sign64(ares, v[cmd.idx][63]);
      end
      OP_SPSET: sp <= ares_fx;
      OP_SPDSET: begin
        speed[cmd.idx] <= sext32(vel[cmd.idx]) + with_sign64(ares_fx, u_neg[cmd.idx]);
      end
      OP_OUTLOAD: begin
        result.pos_x <= pos[0];
        result.pos_y <= pos[1];
        result.pos_z <= pos[2];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pas_ctrl.sv =====
// controller: sequences one particle update over the datapath and the shared unit
`default_nettype none

module pas_ctrl import pas_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  output logic    result_valid,
  input  logic    result_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIFF   = 5'd1;
  localparam logic [4:0] S_NPREP  = 5'd2;
  localparam logic [4:0] S_NSHIFT = 5'd3;
  localparam logic [4:0] S_SQ     = 5'd4;
  localparam logic [4:0] S_SQW    = 5'd5;
  localparam logic [4:0] S_SQRT   = 5'd6;
  localparam logic [4:0] S_SQRTW  = 5'd7;
  localparam logic [4:0] S_NEAR   = 5'd8;
  localparam logic [4:0] S_UDIV   = 5'd9;
  localparam logic [4:0] S_UDIVW  = 5'd10;
  localparam logic [4:0] S_T1     = 5'd11;
  localparam logic [4:0] S_T1W    = 5'd12;
  localparam logic [4:0] S_K      = 5'd13;
  localparam logic [4:0] S_KW     = 5'd14;
  localparam logic [4:0] S_KDT    = 5'd15;
  localparam logic [4:0] S_KDTW   = 5'd16;
  localparam logic [4:0] S_PULL   = 5'd17;
  localparam logic [4:0] S_PULLW  = 5'd18;
  localparam logic [4:0] S_CLCHK  = 5'd19;
  localparam logic [4:0] S_CLMUL  = 5'd20;
  localparam logic [4:0] S_CLMW   = 5'd21;
  localparam logic [4:0] S_CLDIV  = 5'd22;
  localparam logic [4:0] S_CLDW   = 5'd23;
  localparam logic [4:0] S_VSTORE = 5'd24;
  localparam logic [4:0] S_SPMUL  = 5'd25;
  localparam logic [4:0] S_SPW    = 5'd26;
  localparam logic [4:0] S_SPD    = 5'd27;
  localparam logic [4:0] S_SPDW   = 5'd28;
  localparam logic [4:0] S_POS    = 5'd29;
  localparam logic [4:0] S_POSW   = 5'd30;
  localparam logic [4:0] S_OUT    = 5'd31;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] idx;
  logic [1:0] idx_next;
  logic       nsel;
  logic       nsel_next;
  logic       out_load;

  assign item_stall = (state != S_IDLE);
  assign out_load   = (cmd.op == OP_OUTLOAD);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    nsel_next  = nsel;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = OP_LOAD;
          nsel_next  = 1'b0;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_NPREP;
      end
      S_NPREP: begin
        cmd.op     = nsel ? OP_NPREP_V : OP_NPREP_D;
        state_next = S_NSHIFT;
      end
      S_NSHIFT: begin
        if (status.shift_done) begin
          idx_next   = 2'd0;
          state_next = S_SQ;
        end else begin
          cmd.op = OP_NSHIFT;
        end
      end
      S_SQ: begin
        cmd.op     = OP_SQ_MUL;
        state_next = S_SQW;
      end
      S_SQW: begin
        if (status.arith_done) begin
          cmd.op = OP_SQ_ACC;
          if (idx == 2'd2) begin
            state_next = S_SQRT;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_SQ;
          end
        end
      end
      S_SQRT: begin
        cmd.op     = OP_SQRT;
        state_next = S_SQRTW;
      end
      S_SQRTW: begin
        if (status.arith_done) begin
          cmd.op     = nsel ? OP_NV_SET : OP_DIST_SET;
          state_next = nsel ? S_CLCHK : S_NEAR;
        end
      end
      S_NEAR: begin
        idx_next   = 2'd0;
        state_next = status.far ? S_UDIV : S_POS;
      end
      S_UDIV: begin
        cmd.op     = OP_UDIV;
        state_next = S_UDIVW;
      end
      S_UDIVW: begin
        if (status.arith_done) begin
          cmd.op = OP_USET;
          if (idx == 2'd2) begin
            state_next = S_T1;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_UDIV;
          end
        end
      end
      S_T1: begin
        cmd.op     = OP_T1DIV;
        state_next = S_T1W;
      end
      S_T1W: begin
        if (status.arith_done) state_next = S_K;
      end
      S_K: begin
        cmd.op     = OP_KDIV;
        state_next = S_KW;
      end
      S_KW: begin
        if (status.arith_done) state_next = S_KDT;
      end
      S_KDT: begin
        cmd.op     = OP_KDTMUL;
        state_next = S_KDTW;
      end
      S_KDTW: begin
        if (status.arith_done) begin
          cmd.op     = OP_KDTSET;
          idx_next   = 2'd0;
          state_next = S_PULL;
        end
      end
      S_PULL: begin
        cmd.op     = OP_PULLMUL;
        state_next = S_PULLW;
      end
      S_PULLW: begin
        if (status.arith_done) begin
          cmd.op = OP_VSET;
          if (idx == 2'd2) begin
            nsel_next  = 1'b1;
            state_next = S_NPREP;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_PULL;
          end
        end
      end
      S_CLCHK: begin
        idx_next   = 2'd0;
        state_next = status.clamp ? S_CLMUL : S_VSTORE;
      end
      S_CLMUL: begin
        cmd.op     = OP_CLMUL;
        state_next = S_CLMW;
      end
      S_CLMW: begin
        if (status.arith_done) state_next = S_CLDIV;
      end
      S_CLDIV: begin
        cmd.op     = OP_CLDIV;
        state_next = S_CLDW;
      end
      S_CLDW: begin
        if (status.arith_done) begin
          cmd.op = OP_CLSET;
          if (idx == 2'd2) begin
            state_next = S_VSTORE;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_CLMUL;
          end
        end
      end
      S_VSTORE: begin
        cmd.op     = OP_VSTORE;
        state_next = S_SPMUL;
      end
      S_SPMUL: begin
        cmd.op     = OP_SPMUL;
        state_next = S_SPW;
      end
      S_SPW: begin
        if (status.arith_done) begin
          cmd.op     = OP_SPSET;
          idx_next   = 2'd0;
          state_next = S_SPD;
        end
      end
      S_SPD: begin
        cmd.op     = OP_SPDMUL;
        state_next = S_SPDW;
      end
      S_SPDW: begin
        if (status.arith_done) begin
          cmd.op = OP_SPDSET;
          if (idx == 2'd2) begin
            idx_next   = 2'd0;
            state_next = S_POS;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_SPD;
          end
        end
      end
      S_POS: begin
        cmd.op     = OP_POSMUL;
        state_next = S_POSW;
      end
      S_POSW: begin
        if (status.arith_done) begin
          cmd.op = OP_POSSET;
          if (idx == 2'd2) begin
            state_next = S_OUT;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_POS;
          end
        end
      end
      S_OUT: begin
        if (!result_valid || !result_stall) begin
          cmd.op     = OP_OUTLOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= 2'd0;
      nsel         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      nsel  <= nsel_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/particle_attractor_step_core.sv =====
// top level of the particle attractor step core
`default_nettype none

// One particle is pulled toward a target point, one update per input beat.
// item channel: a beat carries dt and the target point (signed Q16.16);
// it is taken when item_valid is high and item_stall is low.
// result channel: a beat carries the new, saturated particle position;
// it leaves when result_valid is high and result_stall is low.
// The block works on one update at a time; item_stall is high from the cycle
// after a beat is taken until that update has been handed to the result register.
// All arithmetic runs on one shared iterative unit: multiply, divide and square
// root. The length normalisation shift runs one bit a cycle.
// The next beat can be taken in the cycle after the result register is loaded.
// A stalled result stays in the output register while the next item is taken;
// its own result waits until the register is free.
// particle_mass is written over the APB port at byte address 0, also read there.
// Reset clears position and velocity to zero, sets the mass to 1.0 and
// empties the result register.

module particle_attractor_step_core import pas_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t              cmd;
  status_t           status;
  logic              cfg_we;
  logic [MASS_W-1:0] mass;

  // a single register: anything with paddr[2] low decodes to particle_mass
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(mass);

  // sequencer
  pas_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // state, scratch registers and the shared arithmetic unit
  pas_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[MASS_W-1:0]),
    .mass      (mass),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== design/pas_checker.sv =====
// port-level checker of the particle attractor step core, bound to the top level
`default_nettype none

module pas_checker import pas_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input result_t     result,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // no result beat straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat valid after reset");

  // one update at a time: a taken beat closes the input
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input open right after a beat was taken");

  // mass write is read back
  a_mass_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[2] && !paddr[1] && !paddr[0]
    |=> prdata == {13'b0, $past(pwdata[18:0])} || paddr[2])
    else $error("mass register read back differs from written value");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

endmodule

bind particle_attractor_step_core pas_checker u_pas_checker (.*);

`default_nettype wire
